// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Request opcodes; the fourth code is ignored by the queue.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the captured request to the cell array
  } cmd_t;

  localparam int unsigned IdW     = 8;
  localparam int unsigned PriW    = 8;
  localparam int unsigned OccW    = 5;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

endpackage

`default_nettype wire

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for queue requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] item_id;
  logic [7:0] item_priority;

  modport source (output valid, output op, output item_id, output item_priority,
                  input ready);
  modport sink   (input valid, input op, input item_id, input item_priority,
                  output ready);
endinterface

interface spq_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] front_id;
  logic [7:0] front_pri;
  logic [4:0] occupancy;
  logic       is_empty;
  logic [1:0] status;

  modport source (output valid, output front_id, output front_pri,
                  output occupancy, output is_empty, output status, input ready);
  modport sink   (input valid, input front_id, input front_pri,
                  input occupancy, input is_empty, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: capture a request, apply it once the response slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl import spq_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  wire  rsp_ready_i,
  output cmd_t cmd_o
);

  fsm_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;

  assign slot_free = !rsp_valid_q || rsp_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (slot_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      FSM_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      FSM_EXEC: begin
        cmd_o.exec = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (cmd_o.exec)                 rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == FSM_EXEC)
    else $error("captured request did not enter execution");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == FSM_EXEC)
    else $error("response raised without an executed request");

endmodule

`default_nettype wire

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell array with parallel compare, request and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  input  wire  [OpW-1:0]     op_i,
  input  wire  [IdW-1:0]     item_id_i,
  input  wire  [PriW-1:0]    item_priority_i,
  output logic [IdW-1:0]     front_id_o,
  output logic [PriW-1:0]    front_pri_o,
  output logic [OccW-1:0]    occupancy_o,
  output logic               is_empty_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned LogD = $clog2(DEPTH);

  // captured request
  logic [OpW-1:0]  op_q;
  logic [IdW-1:0]  id_q;
  logic [PriW-1:0] pri_q;

  // cell array, slot 0 is the front
  logic [IdW-1:0]  cell_id_q  [DEPTH];
  logic [PriW-1:0] cell_pri_q [DEPTH];
  logic [IdW-1:0]  cell_id_d  [DEPTH];
  logic [PriW-1:0] cell_pri_d [DEPTH];
  logic [CntW-1:0] count_q, count_d;
  status_e         status_q, status_d;

  logic [DEPTH-1:0] vld, ge, after, match, rm_pre;
  logic             full, empty, any_match;
  logic             do_ins, do_shl;
  logic [DEPTH-1:0] shl_sel;

  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign any_match = |match;

  // per-cell compares against the captured request
  for (genvar k = 0; k < DEPTH; k++) begin : g_cmp
    assign vld[k]   = (CntW'(k) < count_q);
    assign match[k] = vld[k] && (cell_id_q[k] == id_q);
    if (k == 0) begin : g_front
      // front is displaced only by a strictly higher priority
      assign ge[k]    = vld[k] && (pri_q > cell_pri_q[k]);
      assign after[k] = ge[0] || !vld[k];
    end else begin : g_rest
      assign ge[k]    = vld[k] && (pri_q >= cell_pri_q[k]);
      assign after[k] = ge[0] || !vld[k] || ge[k];
    end
  end

  // prefix OR: rm_pre[k] set when some match sits at or ahead of slot k
  always_comb begin
    rm_pre = match;
    for (int l = 0; l < LogD; l++) begin
      rm_pre = rm_pre | (rm_pre << (1 << l));
    end
  end

  always_comb begin
    do_ins   = 1'b0;
    do_shl   = 1'b0;
    shl_sel  = '0;
    count_d  = count_q;
    status_d = ST_DONE;
    case (op_e'(op_q))
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_shl  = 1'b1;
          shl_sel = '1;
          count_d = count_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!any_match) begin
          status_d = ST_NOTFOUND;
        end else begin
          do_shl  = 1'b1;
          shl_sel = rm_pre;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic take_new, take_prev, take_next;
    if (k == 0) begin : g_first
      assign take_new  = do_ins && after[k];
      assign take_prev = 1'b0;
    end else begin : g_mid
      assign take_new  = do_ins && after[k] && !after[k-1];
      assign take_prev = do_ins && after[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign take_next = 1'b0;
    end else begin : g_notlast
      assign take_next = do_shl && shl_sel[k];
    end

    always_comb begin
      cell_id_d[k]  = cell_id_q[k];
      cell_pri_d[k] = cell_pri_q[k];
      if (take_new) begin
        cell_id_d[k]  = id_q;
        cell_pri_d[k] = pri_q;
      end else if (take_prev) begin
        cell_id_d[k]  = cell_id_q[(k > 0) ? k - 1 : 0];
        cell_pri_d[k] = cell_pri_q[(k > 0) ? k - 1 : 0];
      end else if (take_next) begin
        cell_id_d[k]  = cell_id_q[(k < DEPTH - 1) ? k + 1 : k];
        cell_pri_d[k] = cell_pri_q[(k < DEPTH - 1) ? k + 1 : k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        cell_id_q[k]  <= cell_id_d[k];
        cell_pri_q[k] <= cell_pri_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      id_q  <= item_id_i;
      pri_q <= item_priority_i;
    end
    if (cmd_i.exec) status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // response fields read straight from the array; it only changes on exec,
  // which waits for the previous response to be taken
  logic [CntW+OccW-1:0] occ_ext;
  assign occ_ext          = {{OccW{1'b0}}, count_q};
  assign occupancy_o      = occ_ext[OccW-1:0];
  assign is_empty_o       = empty;
  assign front_id_o       = empty ? '0 : cell_id_q[0];
  assign front_pri_o      = empty ? '0 : cell_pri_q[0];
  assign status_o         = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[1] |-> cell_pri_q[0] >= cell_pri_q[1])
    else $error("front entries out of priority order");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && op_q == OP_POP && !empty |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not decrement the count");

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted (id, priority) queue with insert, pop-front and remove-by-id requests.
// ----------------------------------------------------------------------------
// Each request is first captured at the request port and then applied to
// the cell array, where every slot compares against the request in parallel
// and shifts, loads or holds; the port takes no new request until that update
// is done. The response (front entry, count, empty flag, status) is held until
// taken; the next request is captured meanwhile, but its array update waits
// for the response slot to clear, so a stalled response holds off the request
// port after one more request. A new entry goes ahead of stored entries of
// equal priority, except that it never displaces an equal-priority front
// entry. Inserting into a full queue is dropped with status full.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  spq_req_if.sink          req_i,
  spq_rsp_if.source        rsp_o
);

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (req_i.op),
    .item_id_i        (req_i.item_id),
    .item_priority_i  (req_i.item_priority),
    .front_id_o       (rsp_o.front_id),
    .front_pri_o      (rsp_o.front_pri),
    .occupancy_o      (rsp_o.occupancy),
    .is_empty_o       (rsp_o.is_empty),
    .status_o         (rsp_o.status)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue. Keeps a shadow copy of the
// sorted entry list, predicts front/count/empty/status for every accepted
// request, and checks each response in order under several idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import spq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDepth     = 16;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned BurstLen   = 157;
  // Opcode the queue ignores; not part of op_e.
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [PriW-1:0] FillPri [QDepth] = '{
    8'd100, 8'd100, 8'd200, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128,
    8'd128, 8'd1, 8'd254, 8'd100, 8'd7, 8'd200, 8'd64, 8'd32
  };

  typedef struct packed {
    logic [IdW-1:0]  front_id;
    logic [PriW-1:0] front_pri;
    logic [OccW-1:0] occupancy;
    logic            is_empty;
    status_e         status;
  } reply_t;

  // Shadow of the entry list plus the responses still owed by the queue.
  class spq_shadow;
    logic [IdW-1:0]  ids  [QDepth];
    logic [PriW-1:0] pris [QDepth];
    int unsigned     count;
    reply_t          replies_due [$];
    int unsigned     mismatches;

    function void drop_slot(input int unsigned pos);
      int unsigned k;
      for (k = pos; k + 1 < count; k++) begin
        ids[k]  = ids[k + 1];
        pris[k] = pris[k + 1];
      end
      count--;
    endfunction

    function void note_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                               input logic [PriW-1:0] pri);
      status_e     st;
      int unsigned pos;
      int unsigned k;
      reply_t      r;
      st = ST_DONE;
      case (op)
        OP_INSERT: begin
          if (count >= QDepth) begin
            st = ST_FULL;
          end else begin
            // strictly higher than the head goes first; else ahead of first <= entry
            if (count == 0 || pri > pris[0]) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < count && pri < pris[pos]) pos++;
            end
            for (k = count; k > pos; k--) begin
              ids[k]  = ids[k - 1];
              pris[k] = pris[k - 1];
            end
            ids[pos]  = id;
            pris[pos] = pri;
            count++;
          end
        end
        OP_POP: begin
          if (count == 0) st = ST_EMPTY;
          else drop_slot(0);
        end
        OP_REMOVE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            pos = count;
            for (k = 0; k < count; k++) begin
              if (pos == count && ids[k] == id) pos = k;
            end
            if (pos == count) st = ST_NOTFOUND;
            else drop_slot(pos);
          end
        end
        default: ;
      endcase
      r.front_id  = (count != 0) ? ids[0] : '0;
      r.front_pri = (count != 0) ? pris[0] : '0;
      r.occupancy = OccW'(count);
      r.is_empty  = (count == 0);
      r.status    = st;
      replies_due.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(input reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %p", $time, got);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("front_id", want.front_id, got.front_id);
      compare_field("front_pri", want.front_pri, got.front_pri);
      compare_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
      compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
      compare_field("status", 8'(want.status), 8'(got.status));
    endfunction

    function logic [IdW-1:0] any_stored_id();
      if (count == 0) return IdW'($urandom);
      return ids[$urandom_range(count - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  spq_req_if req ();
  spq_rsp_if rsp ();

  spq_shadow   book = new();
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned cycles;
  bit          filling;

  sorted_priority_queue #(.DEPTH(QDepth)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sorted_priority_queue regression: fail");
      $finish;
    end
  end

  // Response side: check on handshake, then pick next cycle's ready.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        book.check_reply('{front_id: rsp.front_id, front_pri: rsp.front_pri,
                           occupancy: rsp.occupancy, is_empty: rsp.is_empty,
                           status: status_e'(rsp.status)});
      end
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic send_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                              input logic [PriW-1:0] pri);
    while ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.op            <= op;
    req.item_id       <= id;
    req.item_priority <= pri;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    book.note_request(op, id, pri);
  endtask

  // Hold off new requests until every response is back.
  task automatic drain();
    req.valid <= 1'b0;
    while (book.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Alternates fill-heavy and drain-heavy stretches so the queue hits full and empty.
  task automatic random_burst(input int unsigned n);
    int unsigned     i;
    int unsigned     roll;
    logic [OpW-1:0]  op;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
    for (i = 0; i < n; i++) begin
      if (book.count >= QDepth && $urandom_range(3) == 0) filling = 1'b0;
      if (book.count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < 3) op = OpUnused;
      else if (roll < (filling ? 75 : 22)) op = OP_INSERT;
      else if (roll < (filling ? 87 : 60)) op = OP_POP;
      else op = OP_REMOVE;
      id = IdW'($urandom);
      if (op == OP_REMOVE && $urandom_range(9) < 7) id = book.any_stored_id();
      if (op == OP_INSERT && $urandom_range(4) == 0) id = book.any_stored_id();
      case ($urandom_range(3))
        0: pri = PriW'($urandom_range(7));
        1: pri = PriW'($urandom_range(255, 248));
        default: pri = PriW'($urandom);
      endcase
      send_request(op, id, pri);
    end
  endtask

  initial begin
    int unsigned i;
    rst_n             = 1'b0;
    req.valid         = 1'b0;
    req.op            = OP_INSERT;
    req.item_id       = '0;
    req.item_priority = '0;
    req_idle_pct      = 0;
    rsp_stall_pct     = 0;
    cycles            = 0;
    filling           = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: pop, remove and ignored opcode
    send_request(OP_POP, 8'h00, 8'h00);
    send_request(OP_REMOVE, 8'h5A, 8'hFF);
    send_request(OpUnused, 8'hFF, 8'hFF);
    // fill up: ties at head and tail, new head, extremes of id and priority
    for (i = 0; i < QDepth; i++) send_request(OP_INSERT, IdW'(i * 17), FillPri[i]);
    send_request(OP_INSERT, 8'hAA, 8'hFF);
    send_request(OpUnused, 8'h00, 8'h00);
    send_request(OP_REMOVE, 8'h5B, 8'h00);
    send_request(OP_REMOVE, 8'h88, 8'h00);
    send_request(OP_POP, 8'hFF, 8'h00);
    drain();

    random_burst(BurstLen);
    drain();
    req_idle_pct = 59;
    random_burst(BurstLen);
    drain();
    req_idle_pct  = 0;
    rsp_stall_pct = 59;
    random_burst(BurstLen);
    drain();
    req_idle_pct  = 21;
    rsp_stall_pct = 21;
    random_burst(BurstLen);
    drain();
    repeat (8) @(posedge clk);

    if (book.mismatches == 0 && book.replies_due.size() == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
tb/tb.sv
